@@ sv/sha256_byte_stream_hasher_defines.svh @@
// Assertion macros for the SHA-256 byte stream hasher.
// Included by the top level only; depends on nothing else.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Property that must hold on every clock edge outside reset.
`define SBH_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Implication from one cycle to the next.
`define SBH_ASSERT_NEXT(label, cond, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (prop)) else $error(msg);

`endif

@@ sv/sbh_pkg.sv @@
// Shared types and constants for the SHA-256 byte stream hasher.
// Depends on nothing; used by every module of the block.
package sbh_pkg;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } t_item;

    localparam logic [31:0] PAD_MARK_WORD = 32'h8000_0000;
    localparam logic [5:0]  LENGTH_POS    = 6'd56;

    typedef logic [31:0] t_word;
    typedef t_word [7:0] t_hash;

    localparam t_hash INIT_HASH = {
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667};

    function automatic t_word round_k(input logic [5:0] idx);
        t_word k;
        case (idx)
            6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
            6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
            6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
            6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
            6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic t_word rotr(input t_word v, input int n);
        return (v >> n) | (v << (32 - n));
    endfunction

endpackage

@@ sv/sha256_byte_stream_hasher.sv @@
// SHA-256 over a byte stream. An absorb item is registered in the queue and then,
// once the back part is idle, in the block buffer; a 64th byte starts a compression
// (load, 64 rounds, one per cycle, set by the single round unit, and final add). A
// finish item runs one or two padding blocks, then presents eight digest words,
// one per cycle while not stalled. Items queue in a four-entry front queue while
// the back part is busy.
// Depends on sbh_pkg, sbh_queue, sbh_core and the defines header.
module sha256_byte_stream_hasher #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_command,
    input  logic [7:0]  i_data_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import sbh_pkg::*;
    `include "sha256_byte_stream_hasher_defines.svh"

    t_item q_in, q_out;
    logic  q_full, q_valid, q_pop, core_busy;

    assign q_in.command   = i_command;
    assign q_in.data_byte = i_data_byte;
    assign o_stall        = q_full;

    sbh_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (i_valid && !q_full),
        .i_item  (q_in),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_item  (q_out)
    );

    sbh_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (q_valid),
        .i_item        (q_out),
        .o_pop         (q_pop),
        .o_busy        (core_busy),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word),
        .o_valid       (o_valid),
        .i_stall       (i_stall)
    );

    `SBH_ASSERT(a_pop_has_item, !q_pop || q_valid, "pop from empty queue")
    `SBH_ASSERT(a_pop_when_idle, !q_pop || !core_busy, "pop while back part busy")
    `SBH_ASSERT(a_last_idx, !o_valid || (o_last_word == (o_word_index == 3'd7)),
        "last word flag mismatch")
    `SBH_ASSERT_NEXT(a_word_advance, o_valid && !i_stall && !o_last_word,
        o_valid && o_word_index == $past(o_word_index) + 3'd1, "digest word skipped")
endmodule

@@ sv/sbh_queue.sv @@
// Short item queue between the front and back parts of the hasher.
// Depends on sbh_pkg for the item type.
module sbh_queue #(
    parameter int DEPTH = 4
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  sbh_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output sbh_pkg::t_item o_item
);
    import sbh_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    t_item             r_mem [DEPTH];
    logic [AW-1:0]     r_wp, r_rp;
    logic [AW:0]       r_cnt;

    assign o_full  = (r_cnt == (AW+1)'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(i_push) - (AW+1)'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end
endmodule

@@ sv/sbh_core.sv @@
// Back part of the hasher: block buffer, padding sequencer, one-round-per-cycle
// compression with rolling message schedule, and digest output register.
// Depends on sbh_pkg.
module sbh_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  sbh_pkg::t_item i_item,
    output logic           o_pop,
    output logic           o_busy,
    output logic [31:0]    o_digest_word,
    output logic [2:0]     o_word_index,
    output logic           o_last_word,
    output logic           o_valid,
    input  logic           i_stall
);
    import sbh_pkg::*;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_PAD   = 3'd1;
    localparam logic [2:0] ST_ROUND = 3'd2;
    localparam logic [2:0] ST_ADD   = 3'd3;
    localparam logic [2:0] ST_EMIT  = 3'd4;

    logic [2:0]   r_state, n_state;
    t_word        r_blk [16];
    t_hash        r_chain;
    t_word        r_v [8];
    logic [5:0]   r_fill;
    logic [63:0]  r_len;
    logic [5:0]   r_round;
    logic         r_final;   // finish taken: compression is the last of a message unless r_extra is set
    logic         r_extra;   // a second padding block follows this one
    logic [2:0]   r_oidx;
    logic         r_ovalid;
    t_word        r_oword;

    t_word w_t, s0, s1, t1, t2, e, a;
    logic  take;

    assign take  = (r_state == ST_IDLE) && i_valid;
    assign o_pop = take;
    assign o_busy = (r_state != ST_IDLE) || r_ovalid;

    // Schedule word: rounds 0..15 read the buffer directly, later ones expand.
    always_comb begin
        s0  = rotr(r_blk[1], 7) ^ rotr(r_blk[1], 18) ^ (r_blk[1] >> 3);
        s1  = rotr(r_blk[14], 17) ^ rotr(r_blk[14], 19) ^ (r_blk[14] >> 10);
        w_t = r_blk[0];
        e   = r_v[4];
        a   = r_v[0];
        t1  = r_v[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
              + ((e & r_v[5]) ^ (~e & r_v[6])) + round_k(r_round) + w_t;
        t2  = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
              + ((a & r_v[1]) ^ (a & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (take && (i_item.command == CMD_FINISH || r_fill == 6'd63))
                          n_state = (i_item.command == CMD_FINISH) ? ST_PAD : ST_ROUND;
            ST_PAD:   n_state = ST_ROUND;
            ST_ROUND: if (r_round == 6'd63) n_state = ST_ADD;
            ST_ADD:   n_state = r_extra ? ST_PAD : (r_final ? ST_EMIT : ST_IDLE);
            ST_EMIT:  if (r_ovalid && !i_stall && r_oidx == 3'd7) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_chain  <= INIT_HASH;
            r_fill   <= '0;
            r_len    <= '0;
            r_round  <= '0;
            r_final  <= 1'b0;
            r_extra  <= 1'b0;
            r_ovalid <= 1'b0;
            r_oidx   <= '0;
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    r_round <= '0;
                    if (take) begin
                        if (i_item.command == CMD_ABSORB) begin
                            r_len  <= r_len + 64'd1;
                            r_fill <= r_fill + 6'd1;
                            r_final <= 1'b0;
                            r_extra <= 1'b0;
                        end else begin
                            r_final <= 1'b1;
                            r_extra <= (r_fill >= LENGTH_POS);
                        end
                    end
                end
                ST_PAD:   r_round <= '0;
                ST_ROUND: r_round <= r_round + 6'd1;
                ST_ADD: begin
                    for (int i = 0; i < 8; i++) begin
                        r_chain[i] <= r_chain[i] + r_v[i];
                    end
                    r_extra <= 1'b0;
                    if (r_final && !r_extra) begin
                        r_ovalid <= 1'b1;
                        r_oidx   <= '0;
                    end
                    if (r_extra) begin
                        r_fill <= '0;
                    end
                end
                ST_EMIT: begin
                    if (r_ovalid && !i_stall) begin
                        r_oidx <= r_oidx + 3'd1;
                        if (r_oidx == 3'd7) begin
                            r_ovalid <= 1'b0;
                            r_chain  <= INIT_HASH;
                            r_fill   <= '0;
                            r_len    <= '0;
                            r_final  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Datapath registers without reset.
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
                if (take) begin
                    for (int w = 0; w < 16; w++) begin
                        for (int b = 0; b < 4; b++) begin
                            if (r_fill == 6'(w * 4 + b)) begin
                                r_blk[w][31-8*b -: 8] <=
                                    (i_item.command == CMD_ABSORB) ? i_item.data_byte : 8'h80;
                            end else if (i_item.command == CMD_FINISH &&
                                         r_fill < 6'(w * 4 + b)) begin
                                r_blk[w][31-8*b -: 8] <= 8'h00;
                            end
                        end
                    end
                end
            end
            ST_PAD: begin
                // Length goes in the last two words unless another block follows.
                for (int i = 0; i < 8; i++) r_v[i] <= r_chain[i];
                if (!r_extra) begin
                    r_blk[14] <= r_len[60:29];
                    r_blk[15] <= {r_len[28:0], 3'b000};
                end
            end
            ST_ROUND: begin
                for (int i = 0; i < 15; i++) r_blk[i] <= r_blk[i+1];
                r_blk[15] <= r_blk[0] + s0 + r_blk[9] + s1;
                r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
                r_v[4] <= r_v[3] + t1;
                r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
                r_v[0] <= t1 + t2;
            end
            ST_ADD: begin
                if (r_extra) begin
                    for (int i = 0; i < 14; i++) r_blk[i] <= '0;
                end
            end
            default: ;
        endcase
        if (r_state == ST_ADD || (r_state == ST_EMIT && r_ovalid && !i_stall)) begin
            if (r_state == ST_ADD) begin
                r_oword <= r_chain[0] + r_v[0];
            end else begin
                r_oword <= r_chain[3'(r_oidx + 3'd1)];
            end
        end
    end

    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);
    assign o_valid       = r_ovalid;
endmodule
